// ===== rtl/core/hbpu_pkg.sv =====
// Shared types, codes and helpers for the height-map brush point update.
// No dependencies.
package hbpu_pkg;

	localparam int unsigned HEIGHT_W = 24;
	localparam int unsigned REF_W    = 23;
	localparam int unsigned MODE_W   = 3;
	localparam int unsigned ADDR_W   = 4;
	localparam int unsigned DATA_W   = 32;

	typedef logic signed [HEIGHT_W-1:0] height_t;
	typedef logic [MODE_W-1:0]          mode_t;

	// brush mode codes
	localparam mode_t MODE_RAISE   = 3'd0;
	localparam mode_t MODE_HALF    = 3'd1;
	localparam mode_t MODE_FLATTEN = 3'd2;
	localparam mode_t MODE_SMOOTH  = 3'd3;
	localparam mode_t MODE_CUT     = 3'd4;
	localparam mode_t MODE_SLICE   = 3'd5;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_LEVEL = 2'd1;
	localparam logic [1:0] REG_REF   = 2'd2;

	// clip a 26-bit signed sum to the height range
	function automatic height_t sat24(input logic signed [25:0] x);
		height_t r;
		if (x > 26'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (x < -26'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = x[HEIGHT_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/heightmap_brush_point_update.sv =====
// Height-map brush point update: four-stage pipeline, APB register file.
// Depends on hbpu_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | sink      | in_valid / in_stall | point_height, brush_amount,
//          |           |                     | eight neighbor heights
//  out     | source    | out_valid/out_stall | new_height
//  apb     | slave     | psel/penable/pready | paddr, pwdata, prdata
//
// One beat enters per cycle while the pipe does not stall; each result passes
// through the four register stages (pair sums, saturating adds and the
// neighbor total, the neighbor mean, the final clamp/select in the output
// register). A full stage holds while the stage after it is full and cannot
// move, so a stall at the output backs up stage by stage and empty stages
// keep filling. Reset clears the stage valid bits and the three registers.
module heightmap_brush_point_update (
	input  logic                   clk,
	input  logic                   arst_n,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  hbpu_pkg::height_t      point_height,
	input  hbpu_pkg::height_t      brush_amount,
	input  hbpu_pkg::height_t      west_height,
	input  hbpu_pkg::height_t      northwest_height,
	input  hbpu_pkg::height_t      north_height,
	input  hbpu_pkg::height_t      northeast_height,
	input  hbpu_pkg::height_t      east_height,
	input  hbpu_pkg::height_t      southeast_height,
	input  hbpu_pkg::height_t      south_height,
	input  hbpu_pkg::height_t      southwest_height,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output hbpu_pkg::height_t      new_height,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [hbpu_pkg::ADDR_W-1:0] paddr,
	input  logic [hbpu_pkg::DATA_W-1:0] pwdata,
	output logic [hbpu_pkg::DATA_W-1:0] prdata,
	output logic                   pready
);
	import hbpu_pkg::*;

	// ---------------- configuration registers ----------------
	mode_t               brush_mode_q;
	height_t             flatten_level_q;
	logic [REF_W-1:0]    reference_strength_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_mode_q         <= MODE_RAISE;
			flatten_level_q      <= '0;
			reference_strength_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODE:  brush_mode_q         <= pwdata[MODE_W-1:0];
				REG_LEVEL: flatten_level_q      <= pwdata[HEIGHT_W-1:0];
				REG_REF:   reference_strength_q <= pwdata[REF_W-1:0];
				default:   ;  // drop writes beyond the register list
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:  prdata = {{(DATA_W-MODE_W){1'b0}}, brush_mode_q};
			REG_LEVEL: prdata = {{(DATA_W-HEIGHT_W){flatten_level_q[HEIGHT_W-1]}},
			                     flatten_level_q};
			REG_REF:   prdata = {{(DATA_W-REF_W){1'b0}}, reference_strength_q};
			default:   prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// A stage advances when it is empty or the stage after it advances.
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;
	logic in_take;

	assign adv4    = !v_s4 || !out_stall;
	assign adv3    = !v_s3 || adv4;
	assign adv2    = !v_s2 || adv3;
	assign adv1    = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign in_take = in_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: pair sums, raw adds ----------------
	height_t            h_s1, a_s1;
	logic signed [24:0] p0_s1, p1_s1, p2_s1, p3_s1;
	logic signed [24:0] hpa_s1, hma_s1;
	logic signed [25:0] hhalf_s1;
	logic signed [25:0] h26, a26, half26;

	assign h26    = {{2{point_height[HEIGHT_W-1]}}, point_height};
	assign a26    = {{2{brush_amount[HEIGHT_W-1]}}, brush_amount};
	assign half26 = {4'b0000, reference_strength_q[REF_W-1:1]};

	always_ff @(posedge clk) begin
		if (in_take) begin
			h_s1     <= point_height;
			a_s1     <= brush_amount;
			p0_s1    <= 25'(west_height)  + 25'(northwest_height);
			p1_s1    <= 25'(north_height) + 25'(northeast_height);
			p2_s1    <= 25'(east_height)  + 25'(southeast_height);
			p3_s1    <= 25'(south_height) + 25'(southwest_height);
			hpa_s1   <= h26[24:0] + a26[24:0];
			hma_s1   <= h26[24:0] - a26[24:0];
			hhalf_s1 <= h26 + a26 - half26;
		end
	end

	// ---------------- stage 2: saturate, neighbor total, half step ----------------
	height_t            h_s2, a_s2;
	height_t            add_s2, sub_s2, half_s2, hpd_s2, hmd_s2;
	logic signed [26:0] sum_s2;
	logic signed [24:0] d25;

	// floor(A/2): arithmetic shift
	assign d25 = {{2{a_s1[HEIGHT_W-1]}}, a_s1[HEIGHT_W-1:1]};

	always_ff @(posedge clk) begin
		if (v_s1 && adv2) begin
			h_s2    <= h_s1;
			a_s2    <= a_s1;
			add_s2  <= sat24({hpa_s1[24], hpa_s1});
			sub_s2  <= sat24({hma_s1[24], hma_s1});
			half_s2 <= sat24(hhalf_s1);
			hpd_s2  <= sat24({{2{h_s1[HEIGHT_W-1]}}, h_s1} + {d25[24], d25});
			hmd_s2  <= sat24({{2{h_s1[HEIGHT_W-1]}}, h_s1} - {d25[24], d25});
			sum_s2  <= {{2{p0_s1[24]}}, p0_s1} + {{2{p1_s1[24]}}, p1_s1}
			         + {{2{p2_s1[24]}}, p2_s1} + {{2{p3_s1[24]}}, p3_s1};
		end
	end

	// ---------------- stage 3: neighbor mean ----------------
	height_t            h_s3, a_s3, add_s3, sub_s3, half_s3, hpd_s3, hmd_s3, mean_s3;
	logic signed [26:0] sum_adj;

	// truncate toward zero: bias negative totals by seven before the shift
	assign sum_adj = sum_s2 + (sum_s2[26] ? 27'sd7 : 27'sd0);

	always_ff @(posedge clk) begin
		if (v_s2 && adv3) begin
			h_s3    <= h_s2;
			a_s3    <= a_s2;
			add_s3  <= add_s2;
			sub_s3  <= sub_s2;
			half_s3 <= half_s2;
			hpd_s3  <= hpd_s2;
			hmd_s3  <= hmd_s2;
			mean_s3 <= sum_adj[26:3];
		end
	end

	// ---------------- stage 4: clamp and select into the output register ----------------
	height_t new_height_s4;
	height_t res;

	always_comb begin
		case (brush_mode_q)
			MODE_RAISE: res = add_s3;
			MODE_HALF:  res = half_s3;
			MODE_FLATTEN: begin
				if (flatten_level_q > h_s3) begin
					res = (add_s3 > flatten_level_q) ? flatten_level_q : add_s3;
				end else if (flatten_level_q < h_s3) begin
					res = (sub_s3 < flatten_level_q) ? flatten_level_q : sub_s3;
				end else begin
					res = h_s3;
				end
			end
			MODE_SMOOTH: begin
				if (mean_s3 > h_s3) begin
					res = (hpd_s3 > mean_s3) ? mean_s3 : hpd_s3;
				end else if (mean_s3 < h_s3) begin
					res = (hmd_s3 < mean_s3) ? mean_s3 : hmd_s3;
				end else begin
					res = h_s3;
				end
			end
			MODE_CUT: res = (a_s3 > 24'sd0) ? '0 : h_s3;
			MODE_SLICE: begin
				if (h_s3 > flatten_level_q) begin
					res = (sub_s3 < flatten_level_q) ? flatten_level_q : sub_s3;
				end else begin
					res = h_s3;
				end
			end
			default: res = h_s3;  // unused codes pass the height through
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s3 && adv4) begin
			new_height_s4 <= res;
		end
	end

	assign out_valid  = v_s4;
	assign new_height = new_height_s4;

`ifndef SYNTH
	// a free output lets every stage move, so the input never stalls
	a_free_out_no_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output is free");

	// an accepted beat always lands in the first stage
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat lost at stage 1");

	// a stalled result stays in the output register
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && out_stall) |=> (v_s4 && $stable(new_height_s4)))
		else $error("stalled result dropped or changed");

	// the pipe only backs up to the input when every stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input stalled with an empty stage");
`endif

endmodule
